// ----- hw/rtl/smg_pkg.sv -----
`timescale 1ns / 1ps

package smg_pkg;

  // Input operation codes.
  localparam logic OP_MOVE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Configuration register indexes.
  localparam logic REG_PULSES_PER_REV = 1'b0;
  localparam logic REG_PULSE_WIDTH    = 1'b1;

  localparam logic [15:0] PPR_RESET = 16'd200;
  localparam logic [15:0] PW_RESET  = 16'd10;

  // 92160 = 360 * 256 = 2^11 * 45: shift by 11, then divide by 45 with a
  // reciprocal multiply, floor(x * ceil(2^34 / 45) / 2^34), exact for x < 2^28.
  localparam int          DEG_SHIFT     = 11;
  localparam logic [27:0] DEG_ODD       = 28'd45;
  localparam logic [28:0] DEG_RECIP     = 29'd381774871;
  localparam int          DEG_RECIP_SHR = 34;

  localparam int          DIV_W     = 32;
  localparam int          DIV_CNT_W = 5;
  // The move time is 31 bits wide.
  localparam logic [DIV_CNT_W-1:0] ITER_PERIOD = 5'd31;

  localparam logic [31:0] SINCE_SAT = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_RECIP,
    S_DIV_GO,
    S_DIV,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic tick;
    logic move_load;
    logic mul_load;
    logic div_start;
    logic take_target;
    logic take_period;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic steps_zero;
  } status_t;

endpackage

// ----- hw/rtl/smg_div.sv -----
`timescale 1ns / 1ps

module smg_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [smg_pkg::DIV_CNT_W-1:0] iters,
  input  logic [smg_pkg::DIV_W-1:0]     dividend,
  input  logic [smg_pkg::DIV_W-1:0]     divisor,
  output logic [smg_pkg::DIV_W-1:0]     quotient,
  output logic                          done
);
  import smg_pkg::*;

  logic                 busy;
  logic [DIV_CNT_W-1:0] count;
  logic [DIV_W-1:0]     rem;
  logic [DIV_W-1:0]     quo;
  logic [DIV_W-1:0]     dsr;
  logic [DIV_W:0]       rem_sh;
  logic                 fits;

  // The dividend is loaded left-aligned; one quotient bit enters per cycle.
  assign rem_sh = {rem, quo[DIV_W-1]};
  assign fits   = (rem_sh >= {1'b0, dsr});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= busy && (count == DIV_CNT_W'(1));
      if (start) begin
        busy  <= 1'b1;
        count <= iters;
      end else if (busy) begin
        count <= count - DIV_CNT_W'(1);
        if (count == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      if (fits) begin
        rem <= DIV_W'(rem_sh - {1'b0, dsr});
      end else begin
        rem <= rem_sh[DIV_W-1:0];
      end
      quo <= {quo[DIV_W-2:0], fits};
    end
  end

  assign quotient = quo;

endmodule

// ----- hw/rtl/smg_dp.sv -----
`timescale 1ns / 1ps

module smg_dp (
  input  logic                clk,
  input  logic                rst,
  input  smg_pkg::cmd_t       cmd,
  output smg_pkg::status_t    status,
  input  logic                cfg_write,
  input  logic                cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic signed [23:0]  angle,
  input  logic [30:0]         move_time_us,
  output logic                step_level,
  output logic                dir_level,
  output logic                busy_res,
  output logic signed [31:0]  position,
  output logic [31:0]         steps_done
);
  import smg_pkg::*;

  logic [15:0] pulses_per_rev;
  logic [15:0] pulse_width_us;

  logic        active;
  logic        pulse_high;
  logic        dir_positive;
  logic [31:0] step_count;
  logic [31:0] target_steps;
  logic [31:0] step_period;
  logic [31:0] since_pulse_start;
  logic [31:0] step_position;

  logic [23:0] mag;
  logic [30:0] time_us;
  logic [38:0] prod;

  logic [27:0] prod_sh;
  logic [56:0] recip_prod;
  logic [22:0] steps_q;
  logic        steps_zero;

  logic [DIV_W-1:0] div_quo;
  logic             div_done;

  logic        active_next;
  logic        pulse_high_next;
  logic [31:0] step_count_next;
  logic [31:0] since_next;
  logic [31:0] step_position_next;
  logic [31:0] since_inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      pulses_per_rev <= PPR_RESET;
      pulse_width_us <= PW_RESET;
    end else if (cfg_write) begin
      if (cfg_index == REG_PULSES_PER_REV) begin
        pulses_per_rev <= cfg_data;
      end else begin
        pulse_width_us <= cfg_data;
      end
    end
  end

  // Step count: the product shifted by 11, divided by 45 through its reciprocal.
  assign prod_sh    = prod[38:DEG_SHIFT];
  assign recip_prod = {29'd0, prod_sh} * {28'd0, DEG_RECIP};
  assign steps_q    = recip_prod[56:DEG_RECIP_SHR];
  assign steps_zero = (prod_sh < DEG_ODD);

  smg_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .iters    (ITER_PERIOD),
    .dividend ({time_us, 1'b0}),
    .divisor  (target_steps),
    .quotient (div_quo),
    .done     (div_done)
  );

  assign status.div_done   = div_done;
  assign status.steps_zero = steps_zero;

  // One microsecond tick: saturating elapsed count, pulse rise and fall.
  always_comb begin
    active_next        = active;
    pulse_high_next    = pulse_high;
    step_count_next    = step_count;
    step_position_next = step_position;
    since_inc          = (since_pulse_start == SINCE_SAT) ? since_pulse_start
                                                          : since_pulse_start + 32'd1;
    since_next         = since_pulse_start;
    if (active) begin
      since_next = since_inc;
      if (pulse_high) begin
        if (since_inc > {16'd0, pulse_width_us}) begin
          pulse_high_next    = 1'b0;
          step_count_next    = step_count + 32'd1;
          step_position_next = dir_positive ? step_position + 32'd1
                                            : step_position - 32'd1;
        end
      end else if (since_inc > step_period) begin
        pulse_high_next = 1'b1;
        since_next      = '0;
      end
      active_next = (step_count_next != target_steps);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active            <= 1'b0;
      pulse_high        <= 1'b0;
      dir_positive      <= 1'b0;
      step_count        <= '0;
      target_steps      <= '0;
      step_period       <= '0;
      since_pulse_start <= SINCE_SAT;
      step_position     <= '0;
    end else if (cmd.tick) begin
      active            <= active_next;
      pulse_high        <= pulse_high_next;
      step_count        <= step_count_next;
      since_pulse_start <= since_next;
      step_position     <= step_position_next;
    end else if (cmd.move_load) begin
      // A pulse in flight is dropped without being counted.
      active            <= 1'b0;
      pulse_high        <= 1'b0;
      dir_positive      <= !angle[23] && (angle != '0);
      step_count        <= '0;
      since_pulse_start <= SINCE_SAT;
    end else if (cmd.take_target) begin
      target_steps <= {9'd0, steps_q};
      active       <= !steps_zero;
      step_period  <= '0;
    end else if (cmd.take_period) begin
      step_period <= div_quo;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.move_load) begin
      mag     <= angle[23] ? 24'(24'd0 - angle) : angle;
      time_us <= move_time_us;
    end
    if (cmd.mul_load) begin
      prod <= {15'd0, mag} * {23'd0, pulses_per_rev};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      step_level <= pulse_high;
      dir_level  <= dir_positive;
      busy_res   <= active;
      position   <= step_position;
      steps_done <= step_count;
    end
  end

endmodule

// ----- hw/rtl/smg_ctrl.sv -----
`timescale 1ns / 1ps

module smg_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             operation,
  output logic             out_valid,
  input  logic             out_stall,
  input  smg_pkg::status_t status,
  output smg_pkg::cmd_t    cmd
);
  import smg_pkg::*;

  state_t state;
  state_t state_next;
  logic   in_take;
  logic   out_free;

  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = (operation == OP_TICK) ? S_EMIT : S_MUL;
        end
      end
      S_MUL:    state_next = S_RECIP;
      S_RECIP:  state_next = status.steps_zero ? S_EMIT : S_DIV_GO;
      S_DIV_GO: state_next = S_DIV;
      S_DIV: begin
        if (status.div_done) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = (state != S_IDLE);
    case (state)
      S_IDLE: begin
        cmd.tick      = in_take && (operation == OP_TICK);
        cmd.move_load = in_take && (operation == OP_MOVE);
      end
      S_MUL:    cmd.mul_load = 1'b1;
      S_RECIP:  cmd.take_target = 1'b1;
      S_DIV_GO: cmd.div_start = 1'b1;
      S_DIV:    cmd.take_period = status.div_done;
      S_EMIT:   cmd.emit = out_free;
      default:  cmd = '0;
    endcase
  end

`ifndef SYNTHESIS
  a_tick_to_emit: assert property (@(posedge clk) disable iff (rst)
    (in_take && operation == OP_TICK) |=> (state == S_EMIT))
    else $error("tick request did not go straight to the emit state");

  a_emit_waits: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && out_valid && out_stall) |=> (state == S_EMIT))
    else $error("result left the emit state while the output was full");

  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> out_valid)
    else $error("emitted result not presented on the output");

  a_zero_steps: assert property (@(posedge clk) disable iff (rst)
    (state == S_RECIP && status.steps_zero) |=> (state == S_EMIT))
    else $error("zero-step move did not end at once");
`endif

endmodule

// ----- hw/rtl/stepper_move_pulse_generator.sv -----
`timescale 1ns / 1ps

// Step/direction pulse generator for a stepper motor.
// Input channel (in_valid/in_stall): operation selects a move request (angle in
// 1/256 degree, move_time_us) or a one-microsecond tick request.
// Output channel (out_valid/out_stall): one result per input request, giving the
// step and direction levels, the busy flag, the signed position and the steps
// done in the current move.
// Configuration: cfg_write with cfg_index 0 sets pulses_per_rev, index 1 sets
// pulse_width_us; write only while the block is idle.
// Sequence: a tick request goes straight to the emit state, which loads its
// result into the output register once that is free. A move request needs the
// angle multiply, the reciprocal multiply that gives the step count, a divider
// start, 31 one-bit divider steps for the period, a store of the period and the
// output load (a move of zero steps skips the divider); the block then returns
// to idle and can take the next request.
// One request is processed at a time. A finished result waits until the output
// register is free; while a result stalls there, one more request can be taken,
// and in_stall then stays high until the stalled result leaves.
// Reset (rst, synchronous) restores 200 pulses per revolution, a pulse width of
// 10 ticks, an idle motor at position zero and an empty output register.
module stepper_move_pulse_generator (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               operation,
  input  logic signed [23:0] angle,
  input  logic [30:0]        move_time_us,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               step_level,
  output logic               dir_level,
  output logic               busy_res,
  output logic signed [31:0] position,
  output logic [31:0]        steps_done
);
  import smg_pkg::*;

  cmd_t    cmd;
  status_t status;

  smg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .operation (operation),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  smg_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .angle        (angle),
    .move_time_us (move_time_us),
    .step_level   (step_level),
    .dir_level    (dir_level),
    .busy_res     (busy_res),
    .position     (position),
    .steps_done   (steps_done)
  );

endmodule

// ----- sim/stepper_move_pulse_generator_tb.sv -----
`timescale 1ns / 1ps

module stepper_move_pulse_generator_tb;
  import smg_pkg::*;

  localparam int unsigned DEG_UNITS_PER_REV = 92160;
  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned SETTLE_CYCLES = 100;
  localparam int unsigned TICK_CAP = 400;

  typedef struct packed {
    logic        step;
    logic        dir;
    logic        busy;
    logic [31:0] pos;
    logic [31:0] done;
  } motor_status_t;

  class motor_scoreboard;
    logic [15:0] ppr;
    logic [15:0] pw;
    bit active;
    bit pulse_high;
    bit dir_positive;
    logic [31:0] step_count;
    logic [31:0] target_steps;
    logic [31:0] step_period;
    logic [31:0] since_start;
    logic [31:0] step_position;
    motor_status_t status_q[$];
    int unsigned errors;
    int unsigned checked;
    int unsigned moves;
    int unsigned ticks;
    int unsigned steps;
    int unsigned dropped_pulses;

    function new();
      ppr = PPR_RESET;
      pw = PW_RESET;
      active = 1'b0;
      pulse_high = 1'b0;
      dir_positive = 1'b0;
      step_count = '0;
      target_steps = '0;
      step_period = '0;
      since_start = SINCE_SAT;
      step_position = '0;
      errors = 0;
      checked = 0;
      moves = 0;
      ticks = 0;
      steps = 0;
      dropped_pulses = 0;
    endfunction

    function void write_reg(logic idx, logic [15:0] value);
      if (idx == REG_PULSES_PER_REV) ppr = value;
      else pw = value;
    endfunction

    function void begin_move(logic signed [23:0] a, logic [30:0] t);
      logic [24:0] mag;
      logic [63:0] prod;
      if (pulse_high) dropped_pulses++;
      if (a < 0) begin
        mag = 25'h100_0000 - {1'b0, a};
        dir_positive = 1'b0;
      end else begin
        mag = {1'b0, a};
        dir_positive = (a != 0);
      end
      prod = 64'(mag) * 64'(ppr);
      target_steps = 32'(prod / DEG_UNITS_PER_REV);
      step_period = (target_steps != 0) ? {1'b0, t} / target_steps : 32'd0;
      step_count = '0;
      pulse_high = 1'b0;
      since_start = SINCE_SAT;
      active = (target_steps != 0);
    endfunction

    function void advance_tick();
      if (!active) return;
      if (since_start != SINCE_SAT) since_start++;
      if (pulse_high) begin
        // The step only counts once the pulse has been high long enough.
        if (since_start > {16'd0, pw}) begin
          pulse_high = 1'b0;
          step_count++;
          steps++;
          step_position += dir_positive ? 32'd1 : 32'hFFFF_FFFF;
        end
      end else if (since_start > step_period) begin
        pulse_high = 1'b1;
        since_start = '0;
      end
      if (step_count == target_steps) active = 1'b0;
    endfunction

    function void note_request(logic op, logic signed [23:0] a, logic [30:0] t);
      motor_status_t nxt;
      if (op == OP_MOVE) begin
        moves++;
        begin_move(a, t);
      end else begin
        ticks++;
        advance_tick();
      end
      nxt.step = pulse_high;
      nxt.dir = dir_positive;
      nxt.busy = active;
      nxt.pos = step_position;
      nxt.done = step_count;
      status_q.push_back(nxt);
    endfunction

    function void report(string field, logic [31:0] want, logic [31:0] got);
      $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, field, want, got);
      errors++;
    endfunction

    function void check_result(motor_status_t got);
      motor_status_t want;
      if (status_q.size() == 0) begin
        $display("%0t: result with no request outstanding: expected none, actual 0x%0h",
                 $time, got);
        errors++;
        return;
      end
      want = status_q.pop_front();
      checked++;
      if (got.step !== want.step) report("step_level", want.step, got.step);
      if (got.dir !== want.dir) report("dir_level", want.dir, got.dir);
      if (got.busy !== want.busy) report("busy_res", want.busy, got.busy);
      if (got.pos !== want.pos) report("position", want.pos, got.pos);
      if (got.done !== want.done) report("steps_done", want.done, got.done);
    endfunction

    function int pending();
      return status_q.size();
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_write = 1'b0;
  logic               cfg_index = 1'b0;
  logic [15:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               operation = 1'b0;
  logic signed [23:0] angle = '0;
  logic [30:0]        move_time_us = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               step_level;
  logic               dir_level;
  logic               busy_res;
  logic signed [31:0] position;
  logic [31:0]        steps_done;

  motor_scoreboard sb;
  bit quiet = 1'b0;
  int unsigned cycles = 0;
  int unsigned items_sent = 0;
  int unsigned settings = 0;

  stepper_move_pulse_generator dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .operation    (operation),
    .angle        (angle),
    .move_time_us (move_time_us),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .step_level   (step_level),
    .dir_level    (dir_level),
    .busy_res     (busy_res),
    .position     (position),
    .steps_done   (steps_done)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: run exceeded %0d cycles with %0d results outstanding",
               $time, CYCLE_LIMIT, sb.pending());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_result(motor_status_t'{step_level, dir_level, busy_res, position, steps_done});
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(99, 0);
    if (quiet || r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  initial begin
    int unsigned n;
    forever begin
      @(posedge clk);
      n = idle_len();
      if (n == 0) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b1;
        repeat (n - 1) @(posedge clk);
      end
    end
  end

  task automatic send_request(logic op, logic signed [23:0] a, logic [30:0] t);
    int unsigned gap;
    gap = idle_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    angle <= a;
    move_time_us <= t;
    do @(posedge clk); while (in_stall);
    sb.note_request(op, a, t);
    items_sent++;
  endtask

  task automatic send_move(logic signed [23:0] a, logic [30:0] t);
    send_request(OP_MOVE, a, t);
  endtask

  // The angle and time fields of a tick request carry random values.
  task automatic send_tick();
    send_request(OP_TICK, 24'($urandom), 31'($urandom));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic configure(logic [15:0] ppr_v, logic [15:0] pw_v);
    cfg_write <= 1'b1;
    cfg_index <= REG_PULSES_PER_REV;
    cfg_data <= ppr_v;
    @(posedge clk);
    sb.write_reg(REG_PULSES_PER_REV, ppr_v);
    cfg_index <= REG_PULSE_WIDTH;
    cfg_data <= pw_v;
    @(posedge clk);
    sb.write_reg(REG_PULSE_WIDTH, pw_v);
    cfg_write <= 1'b0;
    settings++;
  endtask

  // Mostly a move of a handful of steps, then ticks until it completes or is cut short.
  task automatic move_sequence(int unsigned room);
    int unsigned k;
    int unsigned lo;
    int unsigned hi;
    int unsigned per;
    int unsigned limit;
    int unsigned n;
    logic signed [23:0] a;
    logic [30:0] t;
    if ($urandom_range(99, 0) < 10) begin
      send_move(24'($urandom), 31'($urandom));
      repeat ($urandom_range(20, 1)) send_tick();
      return;
    end
    k = $urandom_range(6, 0);
    lo = (k * DEG_UNITS_PER_REV + sb.ppr - 1) / sb.ppr;
    hi = ((k + 1) * DEG_UNITS_PER_REV + sb.ppr - 1) / sb.ppr - 1;
    if (hi < lo) hi = lo;
    a = 24'($urandom_range(hi, lo));
    if ($urandom_range(1, 0) == 1) a = -a;
    per = ($urandom_range(99, 0) < 80) ? $urandom_range(8, 0) : $urandom_range(40, 9);
    if ($urandom_range(99, 0) < 90) t = 31'(k * per + $urandom_range(k, 0));
    else t = 31'($urandom);
    send_move(a, t);
    if ($urandom_range(99, 0) < 75 && sb.pw < 1000) limit = TICK_CAP;
    else limit = $urandom_range(40, 1);
    // Keep the phase close to its request budget.
    if (limit > room) limit = room;
    n = 0;
    while (sb.active && n < limit) begin
      send_tick();
      n++;
    end
    repeat ($urandom_range(3, 0)) send_tick();
  endtask

  task automatic run_phase(logic [15:0] ppr_v, logic [15:0] pw_v, int unsigned budget);
    int unsigned stop_at;
    configure(ppr_v, pw_v);
    stop_at = items_sent + budget;
    while (items_sent < stop_at) begin
      quiet = ($urandom_range(9, 0) == 0);
      move_sequence(stop_at - items_sent);
    end
    quiet = 1'b0;
    drain();
  endtask

  initial begin
    sb = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: idle tick, zero angle, both angle extremes, a negative angle too
    // small for a step, a zero period, and a move that lands in the middle of a pulse.
    send_tick();
    send_move(24'sd0, 31'd100);
    send_tick();
    send_move(24'sh7F_FFFF, 31'h7FFF_FFFF);
    send_tick();
    send_move(24'sh80_0000, 31'd0);
    send_tick();
    send_move(-24'sd1, 31'd0);
    send_tick();
    send_move(24'sd922, 31'd0);
    repeat (3) send_tick();
    send_move(24'sd461, 31'd3);
    repeat (13) send_tick();
    drain();

    run_phase(16'd1, 16'd0, 250);
    run_phase(16'd65535, 16'd0, 250);
    run_phase(16'd200, 16'd10, 300);
    run_phase(16'd400, 16'd2, 250);
    run_phase(16'd65535, 16'd65535, 100);
    run_phase(16'd1, 16'd65535, 100);
    run_phase(16'd37, 16'd1, 250);
    run_phase(16'd200, 16'd0, 300);

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d requests (%0d moves, %0d ticks) across %0d register settings.",
             items_sent, sb.moves, sb.ticks, settings);
    $display("Checked %0d results; %0d steps completed, %0d moves cut a pulse short.",
             sb.checked, sb.steps, sb.dropped_pulses);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
